/* hw/rtl/efw_pkg.sv */
// ----------------------------------------------------------------------------
// efw_pkg: shared types and constants of the edge frustration weight core
// Widths of magnitudes, signed neighbor sums, spin pair energies and the
// scaled per-pattern share, plus the signed neighbor sum helper.
// ----------------------------------------------------------------------------
package efw_pkg;

    localparam int NEIGH     = 5;
    localparam int PAT_BITS  = NEIGH;
    localparam int CNT_BITS  = 2 * NEIGH;

    typedef logic [8:0]                t_mag;     // clamped edge magnitude, up to 256
    typedef logic [7:0]                t_nmag;    // clamped neighbor magnitude
    typedef logic [NEIGH-1:0][7:0]     t_nvec;
    typedef logic [PAT_BITS-1:0]       t_pat;
    typedef logic signed [11:0]        t_sum;     // +/- 5 * 255
    typedef logic signed [12:0]        t_pair;    // sum or difference of two sums
    typedef logic signed [13:0]        t_energy;
    typedef logic [3:0]                t_share;   // 12 * f / k
    typedef logic [13:0]               t_weight;

    // Share of frustrated minimizers, scaled by 12.
    localparam t_share SHARE_ALL   = 4'd12;
    localparam t_share SHARE_NONE  = 4'd0;
    localparam t_share SHARE_HALF  = 4'd6;
    localparam t_share SHARE_TWO3  = 4'd8;
    localparam t_share SHARE_ONE3  = 4'd4;

    localparam t_weight WEIGHT_MAX = 14'd12288;

    // Signed sum of the neighbor magnitudes; a set pattern bit negates a term.
    function automatic t_sum signed_sum(input t_nvec mags, input t_pat pat);
        t_sum s;
        s = '0;
        for (int k = 0; k < NEIGH; k++) begin
            if (pat[k]) begin
                s = s - t_sum'({4'b0, mags[k]});
            end else begin
                s = s + t_sum'({4'b0, mags[k]});
            end
        end
        return s;
    endfunction

endpackage

/* hw/rtl/efw_share_unit.sv */
// ----------------------------------------------------------------------------
// efw_share_unit: frustrated share of one neighbor sign pattern
// Finds the minimum energy over the four endpoint spin pairs and returns
// twelve times the share of minimizing pairs that have equal spins.
// ----------------------------------------------------------------------------
module efw_share_unit (
    input  efw_pkg::t_sum   i_s0,
    input  efw_pkg::t_sum   i_s1,
    input  efw_pkg::t_mag   i_jmag,
    output efw_pkg::t_share o_share
);

    efw_pkg::t_pair   x;
    efw_pkg::t_pair   y;
    efw_pkg::t_pair   ax;
    efw_pkg::t_pair   ay;
    efw_pkg::t_energy ej;
    efw_pkg::t_energy e_eq;
    efw_pkg::t_energy e_ne;

    // With J = -jmag, equal spins reach J - |S0+S1| and unequal spins reach
    // -J - |S0-S1|; a zero sum or difference makes both pairs of that kind tie.
    always_comb begin
        x    = efw_pkg::t_pair'(i_s0) + efw_pkg::t_pair'(i_s1);
        y    = efw_pkg::t_pair'(i_s0) - efw_pkg::t_pair'(i_s1);
        ax   = x[12] ? -x : x;
        ay   = y[12] ? -y : y;
        ej   = efw_pkg::t_energy'({1'b0, i_jmag});
        e_eq = -ej - efw_pkg::t_energy'(ax);
        e_ne = ej - efw_pkg::t_energy'(ay);
        if (e_eq < e_ne) begin
            o_share = efw_pkg::SHARE_ALL;
        end else if (e_ne < e_eq) begin
            o_share = efw_pkg::SHARE_NONE;
        end else begin
            case ({x == '0, y == '0})
                2'b10:   o_share = efw_pkg::SHARE_TWO3;
                2'b01:   o_share = efw_pkg::SHARE_ONE3;
                default: o_share = efw_pkg::SHARE_HALF;
            endcase
        end
    end

endmodule

/* hw/rtl/edge_frustration_weight_core.sv */
// A negative coupling steps through the pattern states and then a drain state
// that loads the output register and raises the strobe; a non-negative
// coupling gives 0 in the cycle after the start transfer, without going busy.
// The single share unit evaluates one pattern pair per cycle; busy stays high
// until the result is loaded, and start is ignored while busy.
// Reset is synchronous and active low; the receiver cannot stall the strobe.
// ----------------------------------------------------------------------------
// edge_frustration_weight_core: weighted frustration of one Ising edge
// Enumerates the 32 x 32 neighbor sign patterns of both endpoints and sums
// twelve times the frustrated share of each pattern's energy minimizers.
// ----------------------------------------------------------------------------
module edge_frustration_weight_core #(
    parameter int MAX_COUPLING = 255
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [8:0]     i_edge_coupling,
    input  logic [7:0]            i_end0_mag_a,
    input  logic [7:0]            i_end0_mag_b,
    input  logic [7:0]            i_end0_mag_c,
    input  logic [7:0]            i_end0_mag_d,
    input  logic [7:0]            i_end0_mag_e,
    input  logic [7:0]            i_end1_mag_a,
    input  logic [7:0]            i_end1_mag_b,
    input  logic [7:0]            i_end1_mag_c,
    input  logic [7:0]            i_end1_mag_d,
    input  logic [7:0]            i_end1_mag_e,
    output logic                  o_strobe,
    output logic [13:0]           o_frustration_weight
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    localparam logic [16:0] MAX_V = 17'(MAX_COUPLING);

    t_state                  r_state;
    logic [efw_pkg::CNT_BITS-1:0] r_cnt;
    efw_pkg::t_mag           r_jmag;
    efw_pkg::t_nvec          r_m0;
    efw_pkg::t_nvec          r_m1;
    efw_pkg::t_sum           r_s0;
    efw_pkg::t_sum           r_s1;
    logic                    r_pv;
    efw_pkg::t_weight        r_acc;
    efw_pkg::t_weight        r_result;
    logic                    r_strobe;

    efw_pkg::t_nvec          n_m0;
    efw_pkg::t_nvec          n_m1;
    efw_pkg::t_mag           n_jmag;
    logic [9:0]              j_neg;
    efw_pkg::t_sum           n_s0;
    efw_pkg::t_sum           n_s1;
    efw_pkg::t_share         share;
    efw_pkg::t_weight        n_acc;

    // Clamp every magnitude to MAX_COUPLING as the start transfer captures it.
    // The edge magnitude needs nine bits since a coupling of -256 is legal.
    function automatic efw_pkg::t_nmag clamp_n(input logic [7:0] m);
        return ({9'b0, m} > MAX_V) ? MAX_V[7:0] : m;
    endfunction

    always_comb begin
        j_neg  = 10'd0 - {i_edge_coupling[8], i_edge_coupling};
        n_jmag = ({7'b0, j_neg} > MAX_V) ? MAX_V[8:0] : j_neg[8:0];
        n_m0   = {clamp_n(i_end0_mag_e), clamp_n(i_end0_mag_d), clamp_n(i_end0_mag_c),
                  clamp_n(i_end0_mag_b), clamp_n(i_end0_mag_a)};
        n_m1   = {clamp_n(i_end1_mag_e), clamp_n(i_end1_mag_d), clamp_n(i_end1_mag_c),
                  clamp_n(i_end1_mag_b), clamp_n(i_end1_mag_a)};
    end

    // Pattern counter: the upper bits select the endpoint zero signs and the
    // lower bits those of endpoint one. The sums are registered so the share
    // unit and the accumulator form a second stage.
    always_comb begin
        n_s0  = efw_pkg::signed_sum(r_m0, r_cnt[efw_pkg::CNT_BITS-1:efw_pkg::PAT_BITS]);
        n_s1  = efw_pkg::signed_sum(r_m1, r_cnt[efw_pkg::PAT_BITS-1:0]);
        n_acc = r_acc + efw_pkg::t_weight'(share);
    end

    efw_share_unit u_share (
        .i_s0    (r_s0),
        .i_s1    (r_s1),
        .i_jmag  (r_jmag),
        .o_share (share)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_acc    <= '0;
            r_strobe <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // A non-negative coupling is never frustrated and answers
                    // at once; the strobe is low otherwise.
                    r_strobe <= start && !i_edge_coupling[8];
                    if (start) begin
                        r_jmag <= n_jmag;
                        r_m0   <= n_m0;
                        r_m1   <= n_m1;
                        r_cnt  <= '0;
                        r_pv   <= 1'b0;
                        r_acc  <= '0;
                        if (!i_edge_coupling[8]) begin
                            r_result <= '0;
                        end else begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_strobe <= 1'b0;
                    r_s0     <= n_s0;
                    r_s1     <= n_s1;
                    r_pv     <= 1'b1;
                    r_cnt    <= r_cnt + {{(efw_pkg::CNT_BITS-1){1'b0}}, 1'b1};
                    if (r_pv) begin
                        r_acc <= n_acc;
                    end
                    if (&r_cnt) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // The last pattern is still in the second stage.
                    r_pv     <= 1'b0;
                    r_result <= n_acc;
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    assign busy                 = (r_state != S_IDLE);
    assign o_strobe             = r_strobe;
    assign o_frustration_weight = r_result;

    // Leaving the busy phase always delivers the result of the item.
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_strobe)
        else $error("busy fell without a result strobe");

    // A non-negative coupling answers 0 on the next cycle without going busy.
    a_nonneg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_edge_coupling[8] |=>
            o_strobe && (o_frustration_weight == '0) && !busy)
        else $error("non-negative coupling did not give an immediate zero");

    // The sum over all patterns never exceeds twelve per pattern.
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_frustration_weight <= efw_pkg::WEIGHT_MAX))
        else $error("frustration weight out of range");

endmodule
